// ===== sv/sjs_pkg.sv =====
// Package for the job scheduler: field widths, defaults and the
// command/status structs between controller and datapath. No dependencies.
package sjs_pkg;

   localparam int MAX_JOBS_DEF = 64;
   localparam int REL_W        = 16;
   localparam int PROC_W       = 16;
   localparam int DEL_W        = 15;
   localparam int TIME_W       = 23;
   localparam int IDX_W        = 6;

   typedef struct packed {
      logic load;
      logic clear;
      logic start_e;
      logic start_u;
      logic release_job;
      logic jump;
      logic commit_t;
      logic commit_cd;
      logic out_pre;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic found;
      logic due;
      logic ready_any;
      logic all_done;
      logic pre;
   } status_type;

endpackage

// ===== sv/sjs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sjs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/sjs_datapath.sv =====
// Scheduler datapath: job stores, masks, clock, scan unit and result word.
// Depends on sjs_pkg and sjs_ram.
module sjs_datapath #(
   parameter int MAX_JOBS = sjs_pkg::MAX_JOBS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic [sjs_pkg::REL_W-1:0]    req_release_time,
   input  logic [sjs_pkg::PROC_W-1:0]   req_processing_time,
   input  logic [sjs_pkg::DEL_W-1:0]    req_delivery_time,
   input  sjs_pkg::cmd_type             cmd,
   output sjs_pkg::status_type          status,
   output logic [sjs_pkg::IDX_W-1:0]    rsp_job_index,
   output logic [sjs_pkg::TIME_W-1:0]   rsp_completion_time,
   output logic [sjs_pkg::TIME_W-1:0]   rsp_completion_plus_delivery,
   output logic [sjs_pkg::TIME_W-1:0]   rsp_cmax_so_far,
   output logic                         rsp_last_result
);

   localparam int IW  = $clog2(MAX_JOBS);
   localparam int CW  = $clog2(MAX_JOBS + 1);
   localparam int RW  = sjs_pkg::REL_W;
   localparam int DW  = sjs_pkg::DEL_W;
   localparam int TW  = sjs_pkg::TIME_W;

   logic              pre_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [MAX_JOBS-1:0] released_ff, released_in, done_ff, done_in, all_mask;
   logic [TW-1:0]     t_ff, t_in, max_ff, max_in;
   logic [IW-1:0]     run_idx_ff, run_idx_in;
   logic [DW-1:0]     run_del_ff, run_del_in;
   logic              run_vld_ff, run_vld_in;

   logic              active_ff, active_in, kind_ff, kind_in;
   logic [IW-1:0]     addr_ff, addr_in, idx_d_ff;
   logic              vld_d_ff;
   logic              best_vld_ff, best_vld_in;
   logic [IW-1:0]     best_idx_ff, best_idx_in;
   logic [RW-1:0]     best_rel_ff, best_rel_in;
   logic [DW-1:0]     best_del_ff, best_del_in;

   logic [RW+DW-1:0]  key_rd;
   logic [RW-1:0]     rd_rel;
   logic [DW-1:0]     rd_del;
   logic [sjs_pkg::PROC_W-1:0] rem_rd, rem_wr_data;
   logic              rem_wr_en, full, preempt, preempt_wr, cand, last_idx;
   logic [IW-1:0]     rem_wr_addr;
   logic [TW-1:0]     rem_full, t_plus, cd_sum, cmax_next;

   assign full = (count_ff == CW'(MAX_JOBS));

   always_comb begin
      for (int i = 0; i < MAX_JOBS; i++) begin
         all_mask[i] = (CW'(i) < count_ff);
      end
   end

   sjs_ram #(.WIDTH(RW + DW), .DEPTH(MAX_JOBS)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.load & ~full),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data ({req_release_time, req_delivery_time}),
      .rd_addr (addr_ff),
      .rd_data (key_rd)
   );

   // Remaining time: filled at load, rewritten when a run is interrupted.
   assign rem_full    = t_ff - TW'(best_rel_ff);
   assign preempt     = cmd.release_job & pre_ff & run_vld_ff & (best_del_ff > run_del_ff);
   assign preempt_wr  = preempt & (rem_full != '0);
   assign rem_wr_en   = (cmd.load & ~full) | preempt_wr;
   assign rem_wr_addr = cmd.load ? count_ff[IW-1:0] : run_idx_ff;
   assign rem_wr_data = cmd.load ? req_processing_time : rem_full[sjs_pkg::PROC_W-1:0];

   sjs_ram #(.WIDTH(sjs_pkg::PROC_W), .DEPTH(MAX_JOBS)) u_rem_ram (
      .clock   (clock),
      .wr_en   (rem_wr_en),
      .wr_addr (rem_wr_addr),
      .wr_data (rem_wr_data),
      .rd_addr (best_idx_ff),
      .rd_data (rem_rd)
   );

   assign rd_rel   = key_rd[RW+DW-1:DW];
   assign rd_del   = key_rd[DW-1:0];
   assign last_idx = (CW'(idx_d_ff) == count_ff - CW'(1));
   assign t_plus   = t_ff + TW'(rem_rd);
   assign cd_sum   = t_ff + TW'(best_del_ff);
   assign cmax_next = (cd_sum > max_ff) ? cd_sum : max_ff;

   // Scan unit: address counter, read data paired with a delayed index, running best.
   always_comb begin
      active_in   = active_ff;
      addr_in     = addr_ff;
      kind_in     = kind_ff;
      best_vld_in = best_vld_ff;
      best_idx_in = best_idx_ff;
      best_rel_in = best_rel_ff;
      best_del_in = best_del_ff;
      cand        = kind_ff ? (released_ff[idx_d_ff] & ~done_ff[idx_d_ff])
                            : ~released_ff[idx_d_ff];
      if (vld_d_ff && cand) begin
         if (!best_vld_ff || (kind_ff ? (rd_del > best_del_ff) : (rd_rel < best_rel_ff))) begin
            best_vld_in = 1'b1;
            best_idx_in = idx_d_ff;
            best_rel_in = rd_rel;
            best_del_in = rd_del;
         end
      end
      if (cmd.start_e || cmd.start_u) begin
         active_in   = 1'b1;
         addr_in     = '0;
         kind_in     = cmd.start_u;
         best_vld_in = 1'b0;
      end else if (active_ff) begin
         if (CW'(addr_ff) == count_ff - CW'(1)) begin
            active_in = 1'b0;
         end else begin
            addr_in = addr_ff + 1'b1;
         end
      end
   end

   always_comb begin
      released_in = released_ff;
      done_in     = done_ff;
      count_in    = count_ff;
      t_in        = t_ff;
      max_in      = max_ff;
      run_idx_in  = run_idx_ff;
      run_del_in  = run_del_ff;
      run_vld_in  = run_vld_ff;
      if (cmd.clear) begin
         released_in = '0;
         done_in     = '0;
         count_in    = '0;
         t_in        = '0;
         max_in      = '0;
         run_vld_in  = 1'b0;
      end else begin
         if (cmd.load && !full) begin
            count_in = count_ff + 1'b1;
         end
         if (cmd.release_job) begin
            released_in[best_idx_ff] = 1'b1;
            if (preempt) begin
               t_in = TW'(best_rel_ff);
            end
            if (preempt_wr) begin
               done_in[run_idx_ff] = 1'b0;
            end
         end
         if (cmd.jump) begin
            t_in = TW'(best_rel_ff);
         end
         if (cmd.commit_t) begin
            done_in[best_idx_ff] = 1'b1;
            t_in       = t_plus;
            run_idx_in = best_idx_ff;
            run_del_in = best_del_ff;
            run_vld_in = 1'b1;
         end
         if (cmd.commit_cd) begin
            max_in = cmax_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff      <= 1'b0;
         count_ff    <= '0;
         released_ff <= '0;
         done_ff     <= '0;
         t_ff        <= '0;
         max_ff      <= '0;
         run_vld_ff  <= 1'b0;
         active_ff   <= 1'b0;
         vld_d_ff    <= 1'b0;
         best_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pre_ff <= csr_wr_data;
         end
         count_ff    <= count_in;
         released_ff <= released_in;
         done_ff     <= done_in;
         t_ff        <= t_in;
         max_ff      <= max_in;
         run_vld_ff  <= run_vld_in;
         active_ff   <= active_in;
         vld_d_ff    <= active_ff;
         best_vld_ff <= best_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      run_idx_ff  <= run_idx_in;
      run_del_ff  <= run_del_in;
      addr_ff     <= addr_in;
      kind_ff     <= kind_in;
      idx_d_ff    <= addr_ff;
      best_idx_ff <= best_idx_in;
      best_rel_ff <= best_rel_in;
      best_del_ff <= best_del_in;
      if (cmd.commit_cd) begin
         rsp_job_index                <= sjs_pkg::IDX_W'(best_idx_ff);
         rsp_completion_time          <= t_ff;
         rsp_completion_plus_delivery <= cd_sum;
         rsp_cmax_so_far              <= cmax_next;
         rsp_last_result              <= (done_ff == all_mask);
      end else if (cmd.out_pre) begin
         rsp_job_index                <= '0;
         rsp_completion_time          <= '0;
         rsp_completion_plus_delivery <= '0;
         rsp_cmax_so_far              <= max_ff;
         rsp_last_result              <= 1'b1;
      end
   end

   assign status.scan_last = vld_d_ff & last_idx;
   assign status.found     = best_vld_ff;
   assign status.due       = (TW'(best_rel_ff) <= t_ff);
   assign status.ready_any = |(released_ff & ~done_ff);
   assign status.all_done  = (done_ff == all_mask);
   assign status.pre       = pre_ff;

`ifndef NO_ASSERTIONS
   a_released_in_set: assert property (@(posedge clock) disable iff (reset)
      (released_ff & ~all_mask) == '0)
      else $error("released job beyond stored set");
   a_done_released: assert property (@(posedge clock) disable iff (reset)
      (done_ff & ~released_ff) == '0)
      else $error("finished job never released");
   a_commit_has_pick: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_t |-> best_vld_ff)
      else $error("job committed without a scan pick");
`endif

endmodule

// ===== sv/sjs_ctrl.sv =====
// Scheduler controller: load, release sweep, pick, commit and emit sequence.
// Depends on sjs_pkg.
module sjs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_job,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  sjs_pkg::status_type  status,
   output sjs_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_LOAD, S_TOP, S_SCAN_E, S_EVAL_E, S_SCAN_U,
      S_WAIT_REM, S_ADD_T, S_ADD_CD, S_EMIT, S_FIN_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_job) state_in = S_TOP;
            end
         end
         S_TOP: begin
            if (status.all_done) begin
               if (status.pre) begin
                  cmd.out_pre  = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = S_FIN_EMIT;
               end else begin
                  cmd.clear = 1'b1;
                  state_in  = S_LOAD;
               end
            end else begin
               cmd.start_e = 1'b1;
               state_in    = S_SCAN_E;
            end
         end
         S_SCAN_E: begin
            if (status.scan_last) state_in = S_EVAL_E;
         end
         S_EVAL_E: begin
            if (status.found && status.due) begin
               cmd.release_job = 1'b1;
               cmd.start_e     = 1'b1;
               state_in        = S_SCAN_E;
            end else if (status.ready_any) begin
               cmd.start_u = 1'b1;
               state_in    = S_SCAN_U;
            end else begin
               // nothing ready: jump to the next release and start over
               cmd.jump = status.found;
               state_in = S_TOP;
            end
         end
         S_SCAN_U: begin
            if (status.scan_last) state_in = S_WAIT_REM;
         end
         S_WAIT_REM: begin
            state_in = S_ADD_T;
         end
         S_ADD_T: begin
            cmd.commit_t = 1'b1;
            state_in     = S_ADD_CD;
         end
         S_ADD_CD: begin
            cmd.commit_cd = 1'b1;
            if (status.pre) begin
               state_in = S_TOP;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_TOP;
            end
         end
         S_FIN_EMIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               cmd.clear    = 1'b1;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in     = S_LOAD;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_LOAD);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/schrage_job_scheduler.sv =====
// Schrage-rule job scheduler; loading takes one word per cycle, then a run.
// Each step scans the n stored jobs and then decides: release a due job,
// jump an idle clock to the next release, or pick and commit a job, which
// holds its result word until taken (no word per pick in preemptive mode).
// Reset is synchronous: job set, masks, clock and mode clear; no RAM clear.
// Depends on sjs_pkg, sjs_ctrl, sjs_datapath and sjs_ram.
module schrage_job_scheduler #(
   parameter int MAX_JOBS = sjs_pkg::MAX_JOBS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [sjs_pkg::REL_W-1:0]    req_release_time,
   input  logic [sjs_pkg::PROC_W-1:0]   req_processing_time,
   input  logic [sjs_pkg::DEL_W-1:0]    req_delivery_time,
   input  logic                         req_last_job,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sjs_pkg::IDX_W-1:0]    rsp_job_index,
   output logic [sjs_pkg::TIME_W-1:0]   rsp_completion_time,
   output logic [sjs_pkg::TIME_W-1:0]   rsp_completion_plus_delivery,
   output logic [sjs_pkg::TIME_W-1:0]   rsp_cmax_so_far,
   output logic                         rsp_last_result
);

   sjs_pkg::cmd_type    cmd;
   sjs_pkg::status_type status;

   sjs_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_job (req_last_job),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .status       (status),
      .cmd          (cmd)
   );

   sjs_datapath #(.MAX_JOBS(MAX_JOBS)) u_dp (
      .clock                        (clock),
      .reset                        (reset),
      .csr_wr_en                    (csr_wr_en),
      .csr_wr_data                  (csr_wr_data),
      .req_release_time             (req_release_time),
      .req_processing_time          (req_processing_time),
      .req_delivery_time            (req_delivery_time),
      .cmd                          (cmd),
      .status                       (status),
      .rsp_job_index                (rsp_job_index),
      .rsp_completion_time          (rsp_completion_time),
      .rsp_completion_plus_delivery (rsp_completion_plus_delivery),
      .rsp_cmax_so_far              (rsp_cmax_so_far),
      .rsp_last_result              (rsp_last_result)
   );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for schrage_job_scheduler: job sets in both modes,
// checked against a built-in schedule predictor. Depends on sjs_pkg and schrage_job_scheduler.
module tb_top;

   typedef struct {
      logic [sjs_pkg::IDX_W-1:0]  idx;
      logic [sjs_pkg::TIME_W-1:0] done_at;
      logic [sjs_pkg::TIME_W-1:0] done_plus_tail;
      logic [sjs_pkg::TIME_W-1:0] cmax;
      logic                       last;
   } sched_word_type;

   localparam int NJ = sjs_pkg::MAX_JOBS_DEF;

   class sched_board;
      bit                          preempt;
      logic [sjs_pkg::REL_W-1:0]   rel [NJ];
      logic [sjs_pkg::PROC_W-1:0]  left [NJ];
      logic [sjs_pkg::DEL_W-1:0]   tail [NJ];
      int                          njobs;
      sched_word_type              due_q [$];
      int                          errors;
      int                          words_seen;
      int                          sets_run;

      function int earliest(logic [NJ-1:0] pool);
         int best;
         best = NJ;
         for (int i = 0; i < njobs; i++)
            if (pool[i] && (best == NJ || rel[i] < rel[best])) best = i;
         return best;
      endfunction

      function int most_urgent(logic [NJ-1:0] pool);
         int best;
         best = NJ;
         for (int i = 0; i < njobs; i++)
            if (pool[i] && (best == NJ || tail[i] > tail[best])) best = i;
         return best;
      endfunction

      function void schedule_set();
         logic [NJ-1:0]              full_set, rel_mask, done_mask, ready;
         logic [sjs_pkg::TIME_W-1:0] t, cd, cm, rem;
         int                         e, s, running, first;
         sched_word_type             w;
         full_set = (njobs >= NJ) ? '1 : ((64'd1 << njobs) - 64'd1);
         rel_mask = '0;
         done_mask = '0;
         t = '0;
         cm = '0;
         running = NJ;
         first = due_q.size();
         while ((done_mask & full_set) != full_set) begin
            forever begin
               e = earliest(full_set & ~rel_mask);
               if (e >= NJ || rel[e] > t) break;
               rel_mask[e] = 1'b1;
               // a more urgent arrival pulls the clock back to its release
               if (preempt && running < NJ && tail[e] > tail[running]) begin
                  rem = t - sjs_pkg::TIME_W'(rel[e]);
                  t = sjs_pkg::TIME_W'(rel[e]);
                  if (rem != '0) begin
                     left[running] = rem[sjs_pkg::PROC_W-1:0];
                     done_mask[running] = 1'b0;
                  end
               end
            end
            ready = rel_mask & ~done_mask & full_set;
            if (ready == '0) begin
               e = earliest(full_set & ~rel_mask);
               if (e >= NJ) break;
               t = sjs_pkg::TIME_W'(rel[e]);
               continue;
            end
            s = most_urgent(ready);
            done_mask[s] = 1'b1;
            t = t + sjs_pkg::TIME_W'(left[s]);
            cd = t + sjs_pkg::TIME_W'(tail[s]);
            if (cd > cm) cm = cd;
            running = s;
            if (!preempt) begin
               w.idx = sjs_pkg::IDX_W'(s); w.done_at = t; w.done_plus_tail = cd;
               w.cmax = cm; w.last = 1'b0;
               due_q.push_back(w);
            end
         end
         if (preempt) begin
            w.idx = '0; w.done_at = '0; w.done_plus_tail = '0; w.cmax = cm; w.last = 1'b0;
            due_q.push_back(w);
         end
         if (due_q.size() > first) due_q[due_q.size()-1].last = 1'b1;
         njobs = 0;
         sets_run++;
      endfunction

      function void note_job(logic [sjs_pkg::REL_W-1:0] r, logic [sjs_pkg::PROC_W-1:0] p,
                             logic [sjs_pkg::DEL_W-1:0] d, logic lst);
         // drop the job when the store is full
         if (njobs < NJ) begin
            rel[njobs] = r; left[njobs] = p; tail[njobs] = d;
            njobs++;
         end
         if (lst) schedule_set();
      endfunction

      function void check_word(sched_word_type got);
         sched_word_type x;
         words_seen++;
         if (due_q.size() == 0) begin
            $display("%0t: unexpected word idx=%0d cmax=%0d", $realtime, got.idx, got.cmax);
            errors++;
            return;
         end
         x = due_q.pop_front();
         if (got.idx !== x.idx || got.done_at !== x.done_at ||
             got.done_plus_tail !== x.done_plus_tail || got.cmax !== x.cmax ||
             got.last !== x.last) begin
            $display("%0t: mismatch expected idx=%0d c=%0d cd=%0d cmax=%0d last=%0d",
                     $realtime, x.idx, x.done_at, x.done_plus_tail, x.cmax, x.last);
            $display("%0t:          actual   idx=%0d c=%0d cd=%0d cmax=%0d last=%0d",
                     $realtime, got.idx, got.done_at, got.done_plus_tail, got.cmax,
                     got.last);
            errors++;
         end
      endfunction
   endclass

   logic                        clock, reset;
   logic                        csr_wr_en, csr_wr_data;
   logic                        req_valid, req_stall, req_last_job;
   logic [sjs_pkg::REL_W-1:0]   req_release_time;
   logic [sjs_pkg::PROC_W-1:0]  req_processing_time;
   logic [sjs_pkg::DEL_W-1:0]   req_delivery_time;
   logic                        rsp_valid, rsp_stall, rsp_last_result;
   logic [sjs_pkg::IDX_W-1:0]   rsp_job_index;
   logic [sjs_pkg::TIME_W-1:0]  rsp_completion_time, rsp_completion_plus_delivery;
   logic [sjs_pkg::TIME_W-1:0]  rsp_cmax_so_far;

   sched_board sb;
   int         sent;
   int         burst_left;

   schrage_job_scheduler dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_release_time(req_release_time), .req_processing_time(req_processing_time),
      .req_delivery_time(req_delivery_time), .req_last_job(req_last_job),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_job_index(rsp_job_index), .rsp_completion_time(rsp_completion_time),
      .rsp_completion_plus_delivery(rsp_completion_plus_delivery),
      .rsp_cmax_so_far(rsp_cmax_so_far), .rsp_last_result(rsp_last_result)
   );

   always begin
      clock = 1'b0; #4;
      clock = 1'b1; #4;
   end

   initial begin
      #5ms;
      $display("timeout after %0d words", sb.words_seen);
      $display("status: fail");
      $finish;
   end

   // accepted words, sampled at the rising edge
   always @(posedge clock) begin
      sched_word_type w;
      if (!reset && req_valid && !req_stall)
         sb.note_job(req_release_time, req_processing_time, req_delivery_time, req_last_job);
      if (!reset && rsp_valid && !rsp_stall) begin
         w.idx = rsp_job_index; w.done_at = rsp_completion_time;
         w.done_plus_tail = rsp_completion_plus_delivery; w.cmax = rsp_cmax_so_far;
         w.last = rsp_last_result;
         sb.check_word(w);
      end
   end

   // receiver: randomly redrawn stall pattern; one long hold-off
   initial begin
      int pattern, hold, cyc;
      bit held;
      pattern = 0; held = 0; cyc = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 64 == 0) pattern = $urandom_range(3);
         // hold off in the middle of a full set while the sender keeps offering
         if (!held && sb.words_seen >= 20) begin
            held = 1;
            rsp_stall = 1'b1;
            for (hold = 0; hold < 3000; hold++) @(negedge clock);
         end
         case (pattern)
            0: rsp_stall = 1'b0;
            1: rsp_stall = ($urandom_range(99) < 30);
            2: rsp_stall = (cyc % 3 != 0);
            default: rsp_stall = ($urandom_range(99) < 80);
         endcase
      end
   end

   task automatic send_job(int r, int p, int d, bit lst);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(4) == 0 ? 0 : $urandom_range(12);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid = 1'b1;
      req_release_time = sjs_pkg::REL_W'(r);
      req_processing_time = sjs_pkg::PROC_W'(p);
      req_delivery_time = sjs_pkg::DEL_W'(d);
      req_last_job = lst;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
      sent++;
   endtask

   task automatic wait_idle();
      while (sb.due_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_mode(bit m);
      wait_idle();
      csr_wr_en = 1'b1; csr_wr_data = m;
      sb.preempt = m;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // random set: n jobs, releases spread over a window, sometimes full range
   task automatic send_random_set(int n);
      int win, wide;
      win = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 4000);
      wide = ($urandom_range(5) == 0);
      for (int i = 0; i < n; i++)
         send_job(wide ? $urandom_range(65535) : $urandom_range(win),
                  wide ? $urandom_range(65535) : $urandom_range(600),
                  $urandom_range(3) == 0 ? $urandom_range(31) : $urandom_range(32000),
                  i == n - 1);
   endtask

   task automatic random_phase(int quota);
      int start;
      start = sent;
      while (sent - start < quota) send_random_set($urandom_range(1, 8));
   endtask

   initial begin
      sb = new();
      sent = 0; burst_left = 0;
      reset = 1'b1;
      csr_wr_en = 1'b0; csr_wr_data = 1'b0;
      req_valid = 1'b0; req_last_job = 1'b0;
      req_release_time = '0; req_processing_time = '0; req_delivery_time = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // in-order mode: extremes, ties, idle jump
      send_job(65535, 65535, 32000, 1);
      send_job(0, 0, 0, 0);     send_job(0, 0, 0, 1);
      send_job(5, 10, 100, 0);  send_job(5, 20, 300, 0);  send_job(5, 7, 300, 1);
      send_job(0, 5, 1, 0);     send_job(1000, 5, 2, 1);
      // preemptive mode: interrupts, lone job, release exactly at completion
      write_mode(1);
      send_job(0, 100, 10, 0);  send_job(20, 30, 500, 0);
      send_job(30, 5, 20, 0);   send_job(40, 1, 1000, 1);
      send_job(100, 10, 32000, 1);
      send_job(0, 50, 5, 0);    send_job(50, 5, 9, 1);

      // overfull set: the last two jobs are dropped
      write_mode(0);
      send_random_set(66);
      random_phase(50);
      write_mode(1);
      send_random_set(64);
      random_phase(40);
      write_mode(0);
      random_phase(15);
      write_mode(1);
      random_phase(15);

      wait_idle();
      repeat (200) @(posedge clock);
      $display("ran %0d jobs in %0d sets over both modes, checked %0d result words",
               sent, sb.sets_run, sb.words_seen);
      if (sb.errors == 0 && sb.due_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

// ===== schrage_job_scheduler.f =====
sv/sjs_pkg.sv
sv/sjs_ram.sv
sv/sjs_datapath.sv
sv/sjs_ctrl.sv
sv/schrage_job_scheduler.sv
verif/tb_top.sv
